[rtl/scc_pkg.sv]
// shared types and constants for the segment sphere contact pipeline
package scc_pkg;

  localparam int DiffW    = 33;
  localparam int RsumW    = 32;
  localparam int AlongW   = 17;
  localparam int SqdW     = 65;
  localparam int ProdW    = 66;
  localparam int Len2W    = 66;
  localparam int DotW     = 68;
  localparam int RemW     = 83;
  localparam int MulW     = 51;
  localparam int ErrW     = 35;
  localparam int MagW     = 35;
  localparam int SqW      = 67;
  localparam int S2W      = 68;
  localparam int DistW    = 34;
  localparam int DeltaW   = 70;
  localparam int NormRemW = 50;
  localparam int QW       = 15;
  localparam int OvW      = 36;
  localparam int NumDivSt  = AlongW;
  localparam int NumSqrtSt = DistW;
  localparam int NumNormSt = QW;
  localparam int QShift    = 16;
  localparam int NShift    = 14;
  localparam logic [QW-1:0] NormOne = 15'd16384;
  localparam logic signed [MulW-1:0] RoundHalf = 51'sd32768;
  localparam logic signed [OvW-1:0] OvMax = 36'sd2147483647;
  localparam logic signed [OvW-1:0] OvMin = -36'sd2147483648;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ErrW-1:0] err_t;

  typedef struct packed {
    logic signed [31:0] end_a_x;
    logic signed [31:0] end_a_y;
    logic signed [31:0] end_a_z;
    logic signed [31:0] end_b_x;
    logic signed [31:0] end_b_y;
    logic signed [31:0] end_b_z;
    logic signed [31:0] ball_x;
    logic signed [31:0] ball_y;
    logic signed [31:0] ball_z;
    logic               fresh_contact;
    logic [30:0]        rod_radius;
    logic [30:0]        ball_radius;
  } in_item_t;

  typedef struct packed {
    logic               touching;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] overlap;
    logic [16:0]        along_pos;
    logic               degenerate;
  } out_item_t;

  // segment direction, centre offset, radius sum, fresh flag
  typedef struct packed {
    diff_t [2:0]      d;
    diff_t [2:0]      r;
    logic [RsumW-1:0] rsum;
    logic             fresh;
  } geo_t;

  typedef struct packed {
    geo_t             g;
    logic [Len2W-1:0] len2;
    logic [Len2W-1:0] num;
    logic             miss;
    logic             degen_len;
  } proj_t;

  typedef struct packed {
    geo_t              g;
    logic              miss;
    logic              degen_len;
    logic [Len2W-1:0]  len2;
    logic [RemW-1:0]   rem;
    logic [AlongW-1:0] q;
  } div_st_t;

  typedef struct packed {
    geo_t              g;
    logic              miss;
    logic              degen_len;
    logic [AlongW-1:0] along;
  } along_t;

  typedef struct packed {
    err_t [2:0]        e;
    logic [RsumW-1:0]  rsum;
    logic              miss;
    logic              degen_len;
    logic [AlongW-1:0] along;
  } post_t;

  typedef struct packed {
    post_t          p;
    logic [S2W-1:0] s2;
  } resid_t;

  typedef struct packed {
    post_t            p;
    logic [S2W-1:0]   rem;
    logic [DistW-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    post_t            p;
    logic [DistW-1:0] dmag;
  } root_t;

  typedef struct packed {
    logic [2:0][NormRemW-1:0] rem;
    logic [2:0][QW-1:0]       q;
    logic [2:0]               neg;
    logic [DistW-1:0]         dmag;
    logic                     zero;
    logic signed [31:0]       ov;
    logic [AlongW-1:0]        along;
    logic                     miss;
    logic                     degen_len;
  } norm_st_t;

endpackage

[rtl/scc_in_if.sv]
// request channel carrying one segment and sphere pair
interface scc_in_if;
  logic               valid;
  logic               ready;
  scc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/scc_out_if.sv]
// result channel carrying one contact record
interface scc_out_if;
  logic               valid;
  logic               ready;
  scc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/scc_proj.sv]
// front stages: differences, products, dot and squared length, range test
module scc_proj (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  scc_pkg::in_item_t in_item,
  output logic              out_v,
  output scc_pkg::proj_t    out_p
);
  import scc_pkg::*;

  logic                          v1_r, v2_r, v3_r, v4_r;
  geo_t                          g1_r, g2_r, g3_r;
  geo_t                          g1_nxt;
  logic [2:0][SqdW-1:0]          dd_r;
  logic signed [2:0][ProdW-1:0]  dr_r;
  logic [Len2W-1:0]              len2_r;
  logic signed [DotW-1:0]        dot_r;
  proj_t                         p4_r;
  logic signed [ProdW-1:0]       dd_full [3];
  logic signed [ProdW-1:0]       dr_full [3];

  // coordinate differences and radius sum
  always_comb begin
    g1_nxt.d[0] = {in_item.end_b_x[31], in_item.end_b_x} - {in_item.end_a_x[31], in_item.end_a_x};
    g1_nxt.d[1] = {in_item.end_b_y[31], in_item.end_b_y} - {in_item.end_a_y[31], in_item.end_a_y};
    g1_nxt.d[2] = {in_item.end_b_z[31], in_item.end_b_z} - {in_item.end_a_z[31], in_item.end_a_z};
    g1_nxt.r[0] = {in_item.ball_x[31], in_item.ball_x} - {in_item.end_a_x[31], in_item.end_a_x};
    g1_nxt.r[1] = {in_item.ball_y[31], in_item.ball_y} - {in_item.end_a_y[31], in_item.end_a_y};
    g1_nxt.r[2] = {in_item.ball_z[31], in_item.ball_z} - {in_item.end_a_z[31], in_item.end_a_z};
    g1_nxt.rsum = {1'b0, in_item.rod_radius} + {1'b0, in_item.ball_radius};
    g1_nxt.fresh = in_item.fresh_contact;
  end

  // per-axis products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_full[i] = $signed(g1_r.d[i]) * $signed(g1_r.d[i]);
      dr_full[i] = $signed(g1_r.d[i]) * $signed(g1_r.r[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r <= g1_nxt;
      g2_r <= g1_r;
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= dd_full[i][SqdW-1:0];
        dr_r[i] <= dr_full[i];
      end
      g3_r   <= g2_r;
      len2_r <= Len2W'(dd_r[0]) + Len2W'(dd_r[1]) + Len2W'(dd_r[2]);
      dot_r  <= DotW'($signed(dr_r[0])) + DotW'($signed(dr_r[1])) + DotW'($signed(dr_r[2]));
      p4_r.g    <= g3_r;
      p4_r.len2 <= len2_r;
      p4_r.num  <= dot_r[Len2W-1:0];
      p4_r.miss <= (dot_r < 0) || (dot_r > $signed({2'b00, len2_r}));
      p4_r.degen_len <= (len2_r == '0);
    end
  end

  assign out_v = v4_r;
  assign out_p = p4_r;
endmodule

[rtl/scc_along_div.sv]
// restoring divider for the projection position, one quotient bit per stage
module scc_along_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  scc_pkg::proj_t  in_p,
  output logic            out_v,
  output scc_pkg::along_t out_a
);
  import scc_pkg::*;

  logic    v_r  [NumDivSt];
  div_st_t st_r [NumDivSt];
  div_st_t entry;

  // numerator is the dot product scaled by 2^16
  always_comb begin
    entry.g         = in_p.g;
    entry.miss      = in_p.miss;
    entry.degen_len = in_p.degen_len;
    entry.len2      = in_p.len2;
    entry.rem       = RemW'({in_p.num, {QShift{1'b0}}});
    entry.q         = '0;
  end

  for (genvar k = 0; k < NumDivSt; k++) begin : g_st
    div_st_t         cur;
    div_st_t         st_nxt;
    logic            cur_v;
    logic [RemW-1:0] trial;

    if (k == 0) begin : g_first
      assign cur   = entry;
      assign cur_v = in_v;
    end else begin : g_next
      assign cur   = st_r[k-1];
      assign cur_v = v_r[k-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      trial  = RemW'(cur.len2) << (NumDivSt - 1 - k);
      st_nxt = cur;
      if (cur.rem >= trial) begin
        st_nxt.rem = cur.rem - trial;
        st_nxt.q[NumDivSt-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  // zero-length segment projects onto the first end
  always_comb begin
    out_a.g         = st_r[NumDivSt-1].g;
    out_a.miss      = st_r[NumDivSt-1].miss;
    out_a.degen_len = st_r[NumDivSt-1].degen_len;
    out_a.along     = st_r[NumDivSt-1].degen_len ? '0 : st_r[NumDivSt-1].q;
  end

  assign out_v = v_r[NumDivSt-1];
endmodule

[rtl/scc_resid.sv]
// projected point, offset vector, squared distance and fresh contact test
module scc_resid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  scc_pkg::along_t in_a,
  output logic            out_v,
  output scc_pkg::resid_t out_r
);
  import scc_pkg::*;

  logic                         v1_r, v2_r, v3_r, v4_r, v5_r;
  along_t                       a1_r;
  logic signed [2:0][MulW-1:0]  m_r;
  post_t                        p2_r, p3_r, p4_r;
  logic                         fresh2_r, fresh3_r, fresh4_r;
  logic [2:0][SqW-1:0]          sq_r;
  logic [63:0]                  rr2_r, rr2b_r;
  logic [S2W-1:0]               s2_r;
  resid_t                       r5_r;
  post_t                        p5_nxt;
  logic signed [MulW-1:0]       m_full [3];
  logic signed [MulW-1:0]       m_round [3];
  err_t [2:0]                   e_nxt;
  logic signed [2*ErrW-1:0]     sq_full [3];

  // scaled step along the segment
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_full[i] = $signed(in_a.g.d[i]) * $signed({1'b0, in_a.along});
    end
  end

  // round to Q16.16, halves up, then subtract the centre offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_round[i] = ($signed(m_r[i]) + RoundHalf) >>> QShift;
      e_nxt[i] = m_round[i][ErrW-1:0] - {{(ErrW-DiffW){a1_r.g.r[i][DiffW-1]}}, a1_r.g.r[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = $signed(p2_r.e[i]) * $signed(p2_r.e[i]);
    end
  end

  // fresh pair beyond the radius sum becomes a miss
  always_comb begin
    p5_nxt      = p4_r;
    p5_nxt.miss = p4_r.miss || (fresh4_r && (s2_r > S2W'(rr2b_r)));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= in_a;
      for (int i = 0; i < 3; i++) begin
        m_r[i]  <= m_full[i];
        sq_r[i] <= sq_full[i][SqW-1:0];
      end
      p2_r.e         <= e_nxt;
      p2_r.rsum      <= a1_r.g.rsum;
      p2_r.miss      <= a1_r.miss;
      p2_r.degen_len <= a1_r.degen_len;
      p2_r.along     <= a1_r.along;
      fresh2_r       <= a1_r.g.fresh;
      p3_r     <= p2_r;
      fresh3_r <= fresh2_r;
      rr2_r    <= p2_r.rsum * p2_r.rsum;
      p4_r     <= p3_r;
      fresh4_r <= fresh3_r;
      rr2b_r   <= rr2_r;
      s2_r     <= S2W'(sq_r[0]) + S2W'(sq_r[1]) + S2W'(sq_r[2]);
      r5_r.p   <= p5_nxt;
      r5_r.s2  <= s2_r;
    end
  end

  assign out_v = v5_r;
  assign out_r = r5_r;
endmodule

[rtl/scc_sqrt.sv]
// integer square root of the squared distance, one root bit per stage
module scc_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  scc_pkg::resid_t in_r,
  output logic            out_v,
  output scc_pkg::root_t  out_d
);
  import scc_pkg::*;

  logic     v_r  [NumSqrtSt];
  sqrt_st_t st_r [NumSqrtSt];
  sqrt_st_t entry;

  assign entry.p    = in_r.p;
  assign entry.rem  = in_r.s2;
  assign entry.root = '0;

  for (genvar k = 0; k < NumSqrtSt; k++) begin : g_st
    sqrt_st_t          cur;
    sqrt_st_t          st_nxt;
    logic              cur_v;
    logic [DeltaW-1:0] delta;

    if (k == 0) begin : g_first
      assign cur   = entry;
      assign cur_v = in_v;
    end else begin : g_next
      assign cur   = st_r[k-1];
      assign cur_v = v_r[k-1];
    end

    // growth of the square when this root bit is set
    always_comb begin
      delta  = (DeltaW'(cur.root) << (NumSqrtSt - k))
             | (DeltaW'(1) << (2 * (NumSqrtSt - 1 - k)));
      st_nxt = cur;
      if (DeltaW'(cur.rem) >= delta) begin
        st_nxt.rem = cur.rem - delta[S2W-1:0];
        st_nxt.root[NumSqrtSt-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_v      = v_r[NumSqrtSt-1];
  assign out_d.p    = st_r[NumSqrtSt-1].p;
  assign out_d.dmag = st_r[NumSqrtSt-1].root;
endmodule

[rtl/scc_norm.sv]
// normal division in three lanes, overlap saturation and result assembly
module scc_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_v,
  input  scc_pkg::root_t     in_d,
  output logic               out_v,
  output scc_pkg::out_item_t out_item
);
  import scc_pkg::*;

  logic                   v0_r;
  norm_st_t               s0_r;
  norm_st_t               s0_nxt;
  logic                   v_r  [NumNormSt];
  norm_st_t               st_r [NumNormSt];
  logic [MagW-1:0]        mag;
  logic signed [OvW-1:0]  ov_full;
  norm_st_t               fin;
  logic [QW-1:0]          qc [3];
  logic signed [15:0]     nrm [3];

  // magnitudes, rounded numerators, saturated overlap
  always_comb begin
    mag     = '0;
    ov_full = $signed({4'b0000, in_d.p.rsum}) - $signed({2'b00, in_d.dmag});
    for (int i = 0; i < 3; i++) begin
      mag = in_d.p.e[i][ErrW-1] ? MagW'(-in_d.p.e[i]) : MagW'(in_d.p.e[i]);
      s0_nxt.rem[i] = (NormRemW'(mag) << NShift) + NormRemW'(in_d.dmag >> 1);
      s0_nxt.neg[i] = in_d.p.e[i][ErrW-1];
    end
    s0_nxt.q         = '0;
    s0_nxt.dmag      = in_d.dmag;
    s0_nxt.zero      = (in_d.dmag == '0);
    s0_nxt.along     = in_d.p.along;
    s0_nxt.miss      = in_d.p.miss;
    s0_nxt.degen_len = in_d.p.degen_len;
    if (ov_full > OvMax) begin
      s0_nxt.ov = OvMax[31:0];
    end else if (ov_full < OvMin) begin
      s0_nxt.ov = OvMin[31:0];
    end else begin
      s0_nxt.ov = ov_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  for (genvar k = 0; k < NumNormSt; k++) begin : g_st
    norm_st_t            cur;
    norm_st_t            st_nxt;
    logic                cur_v;
    logic [NormRemW-1:0] trial;

    if (k == 0) begin : g_first
      assign cur   = s0_r;
      assign cur_v = v0_r;
    end else begin : g_next
      assign cur   = st_r[k-1];
      assign cur_v = v_r[k-1];
    end

    // one quotient bit in each lane
    always_comb begin
      trial  = NormRemW'(cur.dmag) << (NumNormSt - 1 - k);
      st_nxt = cur;
      for (int i = 0; i < 3; i++) begin
        if (cur.rem[i] >= trial) begin
          st_nxt.rem[i] = cur.rem[i] - trial;
          st_nxt.q[i][NumNormSt-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  // clamp, sign and zero the fields of a miss
  always_comb begin
    fin = st_r[NumNormSt-1];
    for (int i = 0; i < 3; i++) begin
      qc[i]  = (fin.q[i] > NormOne) ? NormOne : fin.q[i];
      nrm[i] = (fin.miss || fin.zero) ? 16'sd0
             : (fin.neg[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]}));
    end
    out_item.touching   = !fin.miss;
    out_item.normal_x   = nrm[0];
    out_item.normal_y   = nrm[1];
    out_item.normal_z   = nrm[2];
    out_item.overlap    = fin.miss ? 32'sd0 : fin.ov;
    out_item.along_pos  = fin.miss ? '0 : fin.along;
    out_item.degenerate = fin.degen_len || (!fin.miss && fin.zero);
  end

  assign out_v = v_r[NumNormSt-1];
endmodule

[rtl/segment_sphere_contact.sv]
// top level of the sphere versus segment contact pipeline
//
//   channel   dir  handshake            payload
//   in_chan   in   valid/ready          segment ends, centre, radii, fresh flag
//   out_chan  out  valid/ready          touching, normal, overlap, position, flag
//
// one request accepted per cycle whenever the output register is empty or taken
// each request passes the 17-stage position divider, 34-stage root and 15-stage normal divider
// rst_n is synchronous and clears every valid bit; datapath registers hold no reset
// the whole pipeline and the output register advance together whenever the output is
// empty or taken, so a stall freezes every stage in place
module segment_sphere_contact (
  input logic       clk,
  input logic       rst_n,
  scc_in_if.sink    in_chan,
  scc_out_if.source out_chan
);
  import scc_pkg::*;

  logic      adv;
  logic      pv, dv, rv, sv, nv;
  proj_t     pj;
  along_t    al;
  resid_t    rs;
  root_t     rt;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;

  // pipeline moves when the output register is free
  assign adv = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  scc_proj u_proj (
    .clk, .rst_n, .adv,
    .in_v(in_chan.valid), .in_item(in_chan.data),
    .out_v(pv), .out_p(pj)
  );

  scc_along_div u_div (
    .clk, .rst_n, .adv,
    .in_v(pv), .in_p(pj),
    .out_v(dv), .out_a(al)
  );

  scc_resid u_resid (
    .clk, .rst_n, .adv,
    .in_v(dv), .in_a(al),
    .out_v(rv), .out_r(rs)
  );

  scc_sqrt u_sqrt (
    .clk, .rst_n, .adv,
    .in_v(rv), .in_r(rs),
    .out_v(sv), .out_d(rt)
  );

  scc_norm u_norm (
    .clk, .rst_n, .adv,
    .in_v(sv), .in_d(rt),
    .out_v(nv), .out_item(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`ifndef SYNTHESIS
  // a result without contact carries no geometry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.touching |->
      out_data_r.normal_x == 16'sd0 && out_data_r.normal_y == 16'sd0 &&
      out_data_r.normal_z == 16'sd0 && out_data_r.overlap == 32'sd0 &&
      out_data_r.along_pos == 17'd0)
    else $error("miss result carries geometry");

  // projection position never passes the second end
  a_along_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.along_pos <= 17'd65536)
    else $error("projection position out of range");

  // normal components stay within one
  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      $signed(out_data_r.normal_x) <= 16'sd16384 &&
      $signed(out_data_r.normal_x) >= -16'sd16384 &&
      $signed(out_data_r.normal_y) <= 16'sd16384 &&
      $signed(out_data_r.normal_y) >= -16'sd16384 &&
      $signed(out_data_r.normal_z) <= 16'sd16384 &&
      $signed(out_data_r.normal_z) >= -16'sd16384)
    else $error("normal component out of range");

  // an all-zero normal on a contact only comes from a zero distance
  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.touching && out_data_r.normal_x == 16'sd0 &&
      out_data_r.normal_y == 16'sd0 && out_data_r.normal_z == 16'sd0 |->
      out_data_r.degenerate)
    else $error("zero normal without degenerate flag");
`endif
endmodule
